@@ hdl/circular_queue_with_reverse_assert.svh @@
// Assertion macros shared by the queue modules.
`ifndef CIRCULAR_QUEUE_WITH_REVERSE_ASSERT_SVH
`define CIRCULAR_QUEUE_WITH_REVERSE_ASSERT_SVH

// Condition must hold at every clock edge outside reset.
`define CQR_ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("queue invariant violated");

// Antecedent implies consequent in the same cycle.
`define CQR_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("queue implication violated");

// Antecedent implies consequent in the following cycle.
`define CQR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("queue sequence violated");

`endif

@@ hdl/cqr_pkg.sv @@
// Shared types and constants of the circular queue with reverse.
`timescale 1ns / 1ps

package cqr_pkg;

  localparam int DEPTH_DEFAULT = 128;
  localparam int DATA_W        = 32;
  localparam int OP_W          = 2;
  localparam int STATUS_W      = 2;
  localparam int OCC_W         = 8;

  localparam logic [OP_W-1:0] OP_ENQ = 2'd0;
  localparam logic [OP_W-1:0] OP_DEQ = 2'd1;
  localparam logic [OP_W-1:0] OP_REV = 2'd2;

  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

  localparam logic signed [DATA_W-1:0] EMPTY_WORD = -1;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_t;

  typedef enum logic [1:0] {
    DSEL_ZERO,
    DSEL_EMPTY,
    DSEL_RAM
  } data_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                enq;
    logic                deq;
    logic                rev;
    logic                res_load;
    logic [STATUS_W-1:0] res_status;
    data_sel_t           res_data_sel;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic empty;
  } stat_t;

endpackage

@@ hdl/circular_queue_with_reverse.sv @@
// Top level of the circular queue with reverse: controller plus datapath.
//
// Usage: drive operation and value and raise start; the transaction is taken
// at a rising edge where start is high and busy is low. Operation codes:
// enqueue, dequeue, reverse stored order; the unused code does nothing.
// Each transaction yields one result on data, status and occupancy, marked
// by done for exactly one cycle; the receiver cannot stall, so sample it then.
// Latency: the result is registered in the cycle after acceptance for enqueue,
// reverse, no-op and an empty dequeue; a dequeue that reads the store passes
// through the registered read port of the entry RAM and then the result
// register.
// Throughput: one transaction per cycle except a reading dequeue, which
// holds busy while the RAM read completes.
// On reverse the ring pointers swap ends and the walk
// direction flips, with no words moved.
// Reset (rst, synchronous): the queue empties, busy and done drop. Store
// contents are left as they were and are never read before being rewritten.
`timescale 1ns / 1ps

module circular_queue_with_reverse import cqr_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [OP_W-1:0]          operation,
  input  logic signed [DATA_W-1:0] value,
  output logic                     done,
  output logic signed [DATA_W-1:0] data,
  output logic [STATUS_W-1:0]      status,
  output logic [OCC_W-1:0]         occupancy
);

  cmd_t  cmd;
  stat_t flags;

  // Decode each transaction and sequence the RAM read of a dequeue.
  cqr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .operation(operation),
    .flags    (flags),
    .cmd      (cmd),
    .busy     (busy)
  );

  // Hold pointers, count and entries; register each result.
  cqr_datapath #(
    .DEPTH(DEPTH)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .value    (value),
    .flags    (flags),
    .data     (data),
    .status   (status),
    .occupancy(occupancy),
    .done     (done)
  );

endmodule

@@ hdl/cqr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module cqr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ hdl/cqr_ctrl.sv @@
// Controller of the circular queue: decodes operations and sequences reads.
`timescale 1ns / 1ps

module cqr_ctrl import cqr_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [OP_W-1:0] operation,
  input  stat_t           flags,
  output cmd_t            cmd,
  output logic            busy
);

  state_t state;
  state_t state_next;
  logic   accept;

  assign accept = start && (state == ST_IDLE);
  assign busy   = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && operation == OP_DEQ && !flags.empty) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd              = '0;
    cmd.res_status   = STAT_OK;
    cmd.res_data_sel = DSEL_ZERO;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (operation)
            OP_ENQ: begin
              if (flags.full) begin
                cmd.res_load   = 1'b1;
                cmd.res_status = STAT_FULL;
              end else begin
                cmd.enq      = 1'b1;
                cmd.res_load = 1'b1;
              end
            end
            OP_DEQ: begin
              if (flags.empty) begin
                cmd.res_load     = 1'b1;
                cmd.res_status   = STAT_EMPTY;
                cmd.res_data_sel = DSEL_EMPTY;
              end else begin
                cmd.deq = 1'b1;
              end
            end
            OP_REV: begin
              cmd.rev      = 1'b1;
              cmd.res_load = 1'b1;
            end
            default: begin
              cmd.res_load = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        cmd.res_load     = 1'b1;
        cmd.res_data_sel = DSEL_RAM;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

`include "circular_queue_with_reverse_assert.svh"

  `CQR_ASSERT_NEXT(a_read_one_cycle, clk, rst, state == ST_READ, state == ST_IDLE)
  `CQR_ASSERT_IMPLIES(a_single_cmd, clk, rst, 1'b1, $onehot0({cmd.enq, cmd.deq, cmd.rev}))

endmodule

@@ hdl/cqr_datapath.sv @@
// Datapath of the circular queue: pointers, count, entry RAM, result registers.
`timescale 1ns / 1ps

module cqr_datapath import cqr_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  cmd_t                       cmd,
  input  logic signed [DATA_W-1:0]   value,
  output stat_t                      flags,
  output logic signed [DATA_W-1:0]   data,
  output logic [STATUS_W-1:0]        status,
  output logic [OCC_W-1:0]           occupancy,
  output logic                       done
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

  logic [AW-1:0]      head;
  logic [AW-1:0]      head_next;
  logic [AW-1:0]      tail;
  logic [AW-1:0]      tail_next;
  logic               dir;
  logic               dir_next;
  logic [CW-1:0]      count;
  logic [CW-1:0]      count_next;
  logic [DATA_W-1:0]  rd_data;
  logic [DATA_W-1:0]  res_data;

  // Advance one slot forward or backward around the ring.
  function automatic logic [AW-1:0] step_slot(input logic [AW-1:0] x, input logic down);
    logic [AW-1:0] r;
    if (down) begin
      r = (x == '0) ? LAST_SLOT : x - 1'b1;
    end else begin
      r = (x == LAST_SLOT) ? '0 : x + 1'b1;
    end
    return r;
  endfunction

  assign flags.full  = (count == CW'(DEPTH));
  assign flags.empty = (count == '0);

  // The logical order runs forward or backward through the ring as dir says;
  // reverse swaps the ends and flips the direction instead of moving words.
  always_comb begin
    head_next  = head;
    tail_next  = tail;
    dir_next   = dir;
    count_next = count;
    if (cmd.enq) begin
      tail_next  = step_slot(tail, dir);
      count_next = count + 1'b1;
    end
    if (cmd.deq) begin
      head_next  = step_slot(head, dir);
      count_next = count - 1'b1;
    end
    if (cmd.rev) begin
      head_next = step_slot(tail, !dir);
      tail_next = step_slot(head, !dir);
      dir_next  = !dir;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      dir   <= 1'b0;
      count <= '0;
      done  <= 1'b0;
    end else begin
      head  <= head_next;
      tail  <= tail_next;
      dir   <= dir_next;
      count <= count_next;
      done  <= cmd.res_load;
    end
  end

  cqr_ram #(
    .WIDTH(DATA_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk    (clk),
    .wr_en  (cmd.enq),
    .wr_addr(tail),
    .wr_data(value),
    .rd_en  (cmd.deq),
    .rd_addr(head),
    .rd_data(rd_data)
  );

  always_comb begin
    case (cmd.res_data_sel)
      DSEL_EMPTY: res_data = EMPTY_WORD;
      DSEL_RAM:   res_data = rd_data;
      default:    res_data = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      data      <= res_data;
      status    <= cmd.res_status;
      occupancy <= OCC_W'(count_next);
    end
  end

`include "circular_queue_with_reverse_assert.svh"

  `CQR_ASSERT_ALWAYS(a_count_bound, clk, rst, count <= CW'(DEPTH))
  `CQR_ASSERT_IMPLIES(a_enq_not_full, clk, rst, cmd.enq, !flags.full)
  `CQR_ASSERT_NEXT(a_deq_count, clk, rst, cmd.deq, count == $past(count) - 1'b1)

endmodule
